// ===== hdl/gqiu_pkg.sv =====
// Package for the Givens-rotation interval update block.
// Holds sizes, operation codes, beat types and the rounding helper.
// No dependencies.
package gqiu_pkg;

    localparam int CHANNELS    = 3;
    localparam int MAX_LEN     = 64;
    localparam int LIN_ROWS    = 2 * MAX_LEN + 2;
    localparam int LIN_DEPTH   = 2 * LIN_ROWS;
    localparam int CONST_DEPTH = MAX_LEN + 1;
    localparam int STORE_DEPTH = CHANNELS * MAX_LEN;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int LIN_AW      = $clog2(LIN_DEPTH);
    localparam int CONST_AW    = $clog2(CONST_DEPTH);
    localparam int COL_W       = $clog2(MAX_LEN);
    localparam int CH_IW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QUEUE_DEPTH = 2;

    localparam int LEN_W  = 7;
    localparam int ERR_W  = 63;
    localparam int DATA_W = 32;

    localparam logic [ERR_W-1:0] ERR_MAX = '1;

    // table entry at row 1, column 0 (length-one pre-rotation)
    localparam int LIN_PRE_ADDR = 2;

    localparam logic [2:0] OP_START      = 3'd0;
    localparam logic [2:0] OP_WRITE      = 3'd1;
    localparam logic [2:0] OP_LOAD_LIN   = 3'd2;
    localparam logic [2:0] OP_LOAD_CONST = 3'd3;
    localparam logic [2:0] OP_ADD        = 3'd4;
    localparam logic [2:0] OP_ROTATE     = 3'd5;
    localparam logic [2:0] OP_READ       = 3'd6;

    typedef struct packed {
        logic [2:0]               operation;
        logic [7:0]               index;
        logic                     column;
        logic [1:0]               channel;
        logic                     last_channel;
        logic signed [DATA_W-1:0] coef_cos;
        logic signed [DATA_W-1:0] coef_sin;
        logic signed [DATA_W-1:0] new_u;
        logic signed [DATA_W-1:0] new_a;
        logic signed [DATA_W-1:0] new_b;
    } gqiu_in_t;

    typedef struct packed {
        logic                     status;
        logic [LEN_W-1:0]         length;
        logic [ERR_W-1:0]         error_sum;
        logic signed [DATA_W-1:0] read_u;
        logic signed [DATA_W-1:0] read_a;
        logic signed [DATA_W-1:0] read_b;
    } gqiu_out_t;

    // classified command between front and back
    typedef struct packed {
        logic     bad;
        gqiu_in_t item;
    } gqiu_cmd_t;

    // round to nearest (ties up) after >> 30, saturate to 32 bits
    function automatic logic signed [DATA_W-1:0] rnd_sat(input logic signed [64:0] p);
        logic signed [65:0] r;
        logic signed [65:0] q;
        r = 66'(p) + 66'sd536870912;
        q = r >>> 30;
        if (q > 66'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (q < -66'sd2147483648)
            return 32'sh80000000;
        else
            return q[31:0];
    endfunction

endpackage

// ===== hdl/gqiu_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gqiu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/gqiu_front.sv =====
// Front end: accepts request beats, flags bad ones, queues them for the back end.
// Depends on gqiu_pkg.
module gqiu_front import gqiu_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  gqiu_in_t  req,
    output logic      cmd_valid,
    input  logic      cmd_pop,
    output gqiu_cmd_t cmd
);

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    gqiu_cmd_t        cls;
    gqiu_cmd_t        q_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]  count_reg, count_next;
    logic             push;
    logic             pop;

    function automatic logic [QP_W-1:0] ptr_inc(input logic [QP_W-1:0] p);
        return (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // stateless range checks; the length check needs back-end state
    always_comb
    begin
        cls.item = req;
        cls.bad  = 1'b0;
        case (req.operation)
            OP_START:               cls.bad = int'(req.index) > MAX_LEN;
            OP_WRITE, OP_READ:      cls.bad = int'(req.index) >= MAX_LEN;
            OP_LOAD_LIN:            cls.bad = int'(req.index) >= LIN_ROWS;
            OP_LOAD_CONST:          cls.bad = int'(req.index) > MAX_LEN;
            OP_ADD:                 cls.bad = 1'b0;
            OP_ROTATE:              cls.bad = (int'(req.index) >= LIN_ROWS)
                                           || (int'(req.index >> 1) >= MAX_LEN);
            default:                cls.bad = 1'b1;
        endcase
        if (req.operation != OP_START && int'(req.channel) >= CHANNELS)
        begin
            cls.bad = 1'b1;
        end
    end

    assign req_ready = count_reg != QC_W'(QUEUE_DEPTH);
    assign push      = req_valid && req_ready;
    assign cmd_valid = count_reg != '0;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== hdl/gqiu_rot.sv =====
// Givens rotation unit: x' = c*x + s*y, y' = c*y - s*x, one shared 32x32 multiplier.
// Depends on gqiu_pkg.
module gqiu_rot import gqiu_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] c,
    input  logic signed [DATA_W-1:0] s,
    input  logic signed [DATA_W-1:0] x,
    input  logic signed [DATA_W-1:0] y,
    output logic                     done,
    output logic signed [DATA_W-1:0] xo,
    output logic signed [DATA_W-1:0] yo
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [2:0]               step_reg, step_next;
    logic signed [DATA_W-1:0] c_reg, s_reg, x_reg, y_reg;
    logic signed [63:0]       prod_reg, prod_next;
    logic signed [64:0]       acc_reg, acc_next;
    logic signed [DATA_W-1:0] xo_reg, xo_next, yo_reg, yo_next;
    logic signed [DATA_W-1:0] mul_a, mul_b;

    always_comb
    begin
        case (step_reg)
            3'd0:    begin mul_a = c_reg; mul_b = x_reg; end
            3'd1:    begin mul_a = s_reg; mul_b = y_reg; end
            3'd2:    begin mul_a = c_reg; mul_b = y_reg; end
            default: begin mul_a = s_reg; mul_b = x_reg; end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        xo_next   = xo_reg;
        yo_next   = yo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            prod_next = mul_a * mul_b;
            step_next = step_reg + 1'b1;
            case (step_reg)
                3'd1:    acc_next = 65'(prod_reg);
                3'd2:    xo_next  = rnd_sat(acc_reg + 65'(prod_reg));
                3'd3:    acc_next = 65'(prod_reg);
                3'd4:
                begin
                    yo_next   = rnd_sat(acc_reg - 65'(prod_reg));
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            c_reg <= c;
            s_reg <= s;
            x_reg <= x;
            y_reg <= y;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        xo_reg   <= xo_next;
        yo_reg   <= yo_next;
    end

    assign done = done_reg;
    assign xo   = xo_reg;
    assign yo   = yo_reg;

endmodule

// ===== hdl/gqiu_back.sv =====
// Back end: sequencer that executes queued commands against the stores and tables.
// Depends on gqiu_pkg, gqiu_ram and gqiu_rot.
module gqiu_back import gqiu_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  gqiu_cmd_t cmd,
    output logic      cmd_pop,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output gqiu_out_t rsp
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_EXEC   = 4'd1;
    localparam logic [3:0] ST_RDWAIT = 4'd2;
    localparam logic [3:0] ST_LD0    = 4'd3;
    localparam logic [3:0] ST_LD1    = 4'd4;
    localparam logic [3:0] ST_GADDR  = 4'd5;
    localparam logic [3:0] ST_GSTART = 4'd6;
    localparam logic [3:0] ST_GWAIT  = 4'd7;
    localparam logic [3:0] ST_SQ     = 4'd8;
    localparam logic [3:0] ST_ACC    = 4'd9;
    localparam logic [3:0] ST_WB0    = 4'd10;
    localparam logic [3:0] ST_WB1    = 4'd11;
    localparam logic [3:0] ST_RESULT = 4'd12;

    // working registers
    localparam logic [2:0] SEL_U0 = 3'd0;
    localparam logic [2:0] SEL_A0 = 3'd1;
    localparam logic [2:0] SEL_Y0 = 3'd2;
    localparam logic [2:0] SEL_Y1 = 3'd3;
    localparam logic [2:0] SEL_B  = 3'd4;
    localparam logic [2:0] SEL_NB = 3'd5;

    logic [3:0]               state_reg, state_next;
    gqiu_cmd_t                cur_reg, cur_next;
    logic                     bad_reg, bad_next;
    logic [2:0]               g_reg, g_next;
    logic [1:0]               e_reg, e_next;
    logic signed [DATA_W-1:0] u0_reg, u0_next, a0_reg, a0_next;
    logic signed [DATA_W-1:0] y0_reg, y0_next, y1_reg, y1_next;
    logic signed [DATA_W-1:0] b_reg, b_next, nb_reg, nb_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [ERR_W-1:0]         err_reg, err_next;
    logic [63:0]              sq_reg, sq_next;
    logic signed [DATA_W-1:0] rd_u_reg, rd_u_next, rd_a_reg, rd_a_next;
    logic signed [DATA_W-1:0] rd_b_reg, rd_b_next;
    gqiu_out_t                rsp_reg, rsp_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic signed [DATA_W-1:0] b_store_reg [CHANNELS];
    logic                     bst_we;
    logic signed [DATA_W-1:0] bst_wdata;

    // RAM ports
    logic                  u_we, a_we, lin_we, const_we;
    logic [STORE_AW-1:0]   u_waddr, a_waddr, st_raddr;
    logic [DATA_W-1:0]     u_wdata, a_wdata, u_rdata, a_rdata;
    logic [LIN_AW-1:0]     lin_waddr, lin_raddr;
    logic [CONST_AW-1:0]   const_waddr, const_raddr;
    logic [63:0]           lin_rdata, const_rdata;

    // rotation unit
    logic                     rot_start, rot_done;
    logic signed [DATA_W-1:0] rot_c, rot_s, rot_x, rot_y, rot_xo, rot_yo;

    // decoded fields of the current command
    logic [2:0]          op;
    logic [7:0]          idx;
    logic [CH_IW-1:0]    ch;
    logic [COL_W-1:0]    col_idx, k_col, h_col;
    logic                k_zero, w_even, len_full;

    // decode of the current rotation step
    logic                g_lin, g_last;
    logic [LIN_AW-1:0]   g_laddr;
    logic [2:0]          g_xs, g_ys;
    logic signed [DATA_W-1:0] x_val, y_val, sq_op;
    logic signed [63:0]  sq_prod;
    logic [63:0]         err_sum;

    function automatic logic [STORE_AW-1:0] store_addr(input logic [CH_IW-1:0] c,
                                                       input logic [COL_W-1:0] col);
        return STORE_AW'(int'(c) * MAX_LEN + int'(col));
    endfunction

    function automatic logic signed [DATA_W-1:0] pick(input logic [2:0] sel,
            input logic signed [DATA_W-1:0] u0, input logic signed [DATA_W-1:0] a0,
            input logic signed [DATA_W-1:0] y0, input logic signed [DATA_W-1:0] y1,
            input logic signed [DATA_W-1:0] b,  input logic signed [DATA_W-1:0] nb);
        case (sel)
            SEL_U0:  return u0;
            SEL_A0:  return a0;
            SEL_Y0:  return y0;
            SEL_Y1:  return y1;
            SEL_B:   return b;
            default: return nb;
        endcase
    endfunction

    assign op       = cur_reg.item.operation;
    assign idx      = cur_reg.item.index;
    assign ch       = CH_IW'(cur_reg.item.channel);
    assign col_idx  = COL_W'(idx);
    assign k_col    = COL_W'(idx >> 1);
    assign h_col    = COL_W'(len_reg);
    assign k_zero   = (idx >> 1) == 8'd0;
    assign w_even   = ~idx[0];
    assign len_full = int'(len_reg) >= MAX_LEN;

    // rotation step table
    always_comb
    begin
        g_lin   = 1'b1;
        g_laddr = LIN_AW'(LIN_PRE_ADDR);
        g_xs    = SEL_U0;
        g_ys    = SEL_A0;
        g_last  = 1'b0;
        if (op == OP_ADD)
        begin
            g_last = g_reg == 3'd5;
            case (g_reg)
                3'd0:
                begin
                    g_laddr = LIN_AW'(LIN_PRE_ADDR);
                end
                3'd1:
                begin
                    g_laddr = LIN_AW'(4 * int'(len_reg));
                    g_ys    = SEL_Y0;
                end
                3'd2:
                begin
                    g_laddr = LIN_AW'(4 * int'(len_reg) + 1);
                    g_xs    = SEL_A0;
                    g_ys    = SEL_Y0;
                end
                3'd3:
                begin
                    g_laddr = LIN_AW'(4 * int'(len_reg) + 2);
                    g_ys    = SEL_Y1;
                end
                3'd4:
                begin
                    g_laddr = LIN_AW'(4 * int'(len_reg) + 3);
                    g_xs    = SEL_A0;
                    g_ys    = SEL_Y1;
                end
                default:
                begin
                    g_lin = 1'b0;
                    g_xs  = SEL_B;
                    g_ys  = SEL_NB;
                end
            endcase
        end
        else
        begin
            // rotate at row w; row 0 and row 1 pair column 0 of u and a
            g_last = (idx == 8'd0) ? (g_reg == 3'd0) : (g_reg == 3'd1);
            if (g_reg == 3'd0)
            begin
                g_laddr = (idx == 8'd0) ? LIN_AW'(LIN_PRE_ADDR) : LIN_AW'(2 * int'(idx));
                g_xs    = SEL_U0;
                g_ys    = k_zero ? SEL_A0 : SEL_Y0;
            end
            else
            begin
                g_laddr = LIN_AW'(2 * int'(idx) + 1);
                g_xs    = SEL_A0;
                g_ys    = k_zero ? SEL_A0 : SEL_Y0;
            end
        end
    end

    assign x_val = pick(g_xs, u0_reg, a0_reg, y0_reg, y1_reg, b_reg, nb_reg);
    assign y_val = pick(g_ys, u0_reg, a0_reg, y0_reg, y1_reg, b_reg, nb_reg);

    assign lin_raddr   = g_laddr;
    assign const_raddr = CONST_AW'(len_reg);
    assign rot_c       = g_lin ? lin_rdata[63:32] : const_rdata[63:32];
    assign rot_s       = g_lin ? lin_rdata[31:0] : const_rdata[31:0];
    assign rot_x       = x_val;
    assign rot_y       = y_val;

    assign sq_op   = (e_reg == 2'd0) ? y0_reg : ((e_reg == 2'd1) ? y1_reg : nb_reg);
    assign sq_prod = sq_op * sq_op;
    assign err_sum = {1'b0, err_reg} + sq_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        bad_next       = bad_reg;
        g_next         = g_reg;
        e_next         = e_reg;
        u0_next        = u0_reg;
        a0_next        = a0_reg;
        y0_next        = y0_reg;
        y1_next        = y1_reg;
        b_next         = b_reg;
        nb_next        = nb_reg;
        len_next       = len_reg;
        err_next       = err_reg;
        sq_next        = sq_reg;
        rd_u_next      = rd_u_reg;
        rd_a_next      = rd_a_reg;
        rd_b_next      = rd_b_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = (rsp_valid_reg && rsp_ready) ? 1'b0 : rsp_valid_reg;
        cmd_pop        = 1'b0;
        rot_start      = 1'b0;
        bst_we         = 1'b0;
        bst_wdata      = b_reg;
        u_we           = 1'b0;
        a_we           = 1'b0;
        u_waddr        = store_addr(ch, '0);
        a_waddr        = store_addr(ch, '0);
        u_wdata        = u0_reg;
        a_wdata        = a0_reg;
        st_raddr       = store_addr(ch, '0);
        lin_we         = 1'b0;
        lin_waddr      = LIN_AW'(2 * int'(idx) + int'(cur_reg.item.column));
        const_we       = 1'b0;
        const_waddr    = CONST_AW'(idx);

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cur_next   = cmd;
                    bad_next   = cmd.bad;
                    rd_u_next  = '0;
                    rd_a_next  = '0;
                    rd_b_next  = '0;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_RESULT;
                if (!bad_reg)
                begin
                    case (op)
                        OP_START:
                        begin
                            len_next = LEN_W'(idx);
                            err_next = '0;
                        end
                        OP_WRITE:
                        begin
                            u_we      = 1'b1;
                            a_we      = 1'b1;
                            u_waddr   = store_addr(ch, col_idx);
                            a_waddr   = store_addr(ch, col_idx);
                            u_wdata   = cur_reg.item.new_u;
                            a_wdata   = cur_reg.item.new_a;
                            bst_we    = 1'b1;
                            bst_wdata = cur_reg.item.new_b;
                        end
                        OP_LOAD_LIN:
                        begin
                            lin_we = 1'b1;
                        end
                        OP_LOAD_CONST:
                        begin
                            const_we = 1'b1;
                        end
                        OP_READ:
                        begin
                            st_raddr   = store_addr(ch, col_idx);
                            state_next = ST_RDWAIT;
                        end
                        OP_ADD:
                        begin
                            if (len_full)
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                y0_next    = cur_reg.item.new_u;
                                y1_next    = cur_reg.item.new_a;
                                b_next     = b_store_reg[ch];
                                nb_next    = cur_reg.item.new_b;
                                g_next     = (len_reg == LEN_W'(1)) ? 3'd0 : 3'd1;
                                state_next = ST_LD0;
                            end
                        end
                        OP_ROTATE:
                        begin
                            g_next     = 3'd0;
                            state_next = ST_LD0;
                        end
                        default:
                        begin
                            bad_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_RDWAIT:
            begin
                rd_u_next  = u_rdata;
                rd_a_next  = a_rdata;
                rd_b_next  = b_store_reg[ch];
                state_next = ST_RESULT;
            end

            ST_LD0:
            begin
                u0_next = u_rdata;
                a0_next = a_rdata;
                if (op == OP_ROTATE && !k_zero)
                begin
                    st_raddr   = store_addr(ch, k_col);
                    state_next = ST_LD1;
                end
                else
                begin
                    state_next = ST_GADDR;
                end
            end

            ST_LD1:
            begin
                y0_next    = w_even ? u_rdata : a_rdata;
                state_next = ST_GADDR;
            end

            ST_GADDR:
            begin
                state_next = ST_GSTART;
            end

            ST_GSTART:
            begin
                rot_start  = 1'b1;
                state_next = ST_GWAIT;
            end

            ST_GWAIT:
            begin
                if (rot_done)
                begin
                    // x result first; on aliased operands the y result wins
                    case (g_xs)
                        SEL_U0:  u0_next = rot_xo;
                        SEL_A0:  a0_next = rot_xo;
                        SEL_B:   b_next  = rot_xo;
                        default: u0_next = u0_reg;
                    endcase
                    case (g_ys)
                        SEL_A0:  a0_next = rot_yo;
                        SEL_Y0:  y0_next = rot_yo;
                        SEL_Y1:  y1_next = rot_yo;
                        SEL_NB:  nb_next = rot_yo;
                        default: y0_next = y0_reg;
                    endcase
                    if (g_last)
                    begin
                        e_next     = 2'd0;
                        state_next = (op == OP_ADD && len_reg != '0) ? ST_SQ : ST_WB0;
                    end
                    else
                    begin
                        g_next     = g_reg + 1'b1;
                        state_next = ST_GADDR;
                    end
                end
            end

            ST_SQ:
            begin
                sq_next    = sq_prod;
                state_next = ST_ACC;
            end

            ST_ACC:
            begin
                err_next = (err_sum > {1'b0, ERR_MAX}) ? ERR_MAX : err_sum[ERR_W-1:0];
                if (e_reg == 2'd2)
                begin
                    state_next = ST_WB0;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_SQ;
                end
            end

            ST_WB0:
            begin
                u_we = 1'b1;
                a_we = 1'b1;
                if (op == OP_ADD)
                begin
                    bst_we = 1'b1;
                end
                state_next = (op == OP_ROTATE && k_zero) ? ST_RESULT : ST_WB1;
            end

            ST_WB1:
            begin
                if (op == OP_ADD)
                begin
                    if (len_reg < LEN_W'(2))
                    begin
                        u_we    = 1'b1;
                        a_we    = 1'b1;
                        u_waddr = store_addr(ch, h_col);
                        a_waddr = store_addr(ch, h_col);
                        u_wdata = y0_reg;
                        a_wdata = y1_reg;
                    end
                    if (cur_reg.item.last_channel)
                    begin
                        len_next = len_reg + 1'b1;
                    end
                end
                else if (w_even)
                begin
                    u_we    = 1'b1;
                    u_waddr = store_addr(ch, k_col);
                    u_wdata = y0_reg;
                end
                else
                begin
                    a_we    = 1'b1;
                    a_waddr = store_addr(ch, k_col);
                    a_wdata = y0_reg;
                end
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status    = bad_reg;
                    rsp_next.length    = len_reg;
                    rsp_next.error_sum = err_reg;
                    rsp_next.read_u    = bad_reg ? '0 : rd_u_reg;
                    rsp_next.read_a    = bad_reg ? '0 : rd_a_reg;
                    rsp_next.read_b    = bad_reg ? '0 : rd_b_reg;
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_W'(1);
            err_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            err_reg       <= err_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        bad_reg  <= bad_next;
        g_reg    <= g_next;
        e_reg    <= e_next;
        u0_reg   <= u0_next;
        a0_reg   <= a0_next;
        y0_reg   <= y0_next;
        y1_reg   <= y1_next;
        b_reg    <= b_next;
        nb_reg   <= nb_next;
        sq_reg   <= sq_next;
        rd_u_reg <= rd_u_next;
        rd_a_reg <= rd_a_next;
        rd_b_reg <= rd_b_next;
        rsp_reg  <= rsp_next;
        if (bst_we)
        begin
            b_store_reg[ch] <= bst_wdata;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    gqiu_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (st_raddr),
        .rdata (u_rdata)
    );

    gqiu_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (st_raddr),
        .rdata (a_rdata)
    );

    gqiu_ram #(.WIDTH(64), .DEPTH(LIN_DEPTH)) lin_table (
        .clk   (clk),
        .we    (lin_we),
        .waddr (lin_waddr),
        .wdata ({cur_reg.item.coef_cos, cur_reg.item.coef_sin}),
        .raddr (lin_raddr),
        .rdata (lin_rdata)
    );

    gqiu_ram #(.WIDTH(64), .DEPTH(CONST_DEPTH)) const_table (
        .clk   (clk),
        .we    (const_we),
        .waddr (const_waddr),
        .wdata ({cur_reg.item.coef_cos, cur_reg.item.coef_sin}),
        .raddr (const_raddr),
        .rdata (const_rdata)
    );

    gqiu_rot rot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rot_start),
        .c     (rot_c),
        .s     (rot_s),
        .x     (rot_x),
        .y     (rot_y),
        .done  (rot_done),
        .xo    (rot_xo),
        .yo    (rot_yo)
    );

endmodule

// ===== hdl/givens_qr_interval_update.sv =====
// Top level of the Givens-rotation interval update block.
// Depends on gqiu_pkg, gqiu_front and gqiu_back.
//
// Usage:
//  - req channel (req_valid/req_ready/req): one operation per beat: start an
//    interval, write a column, load a linear or constant table row, add one
//    channel of a point, rotate linear data at row w, or read a column.
//  - rsp channel (rsp_valid/rsp_ready/rsp): exactly one beat per request, in
//    order, with status, length, error sum and (for reads) stored data.
//  - The front end checks ranges and queues up to two beats; req_ready drops
//    only while two beats wait for the back end.
//  - Beats are executed one at a time by the back-end sequencer and its one
//    shared 32x32 multiplier (four products per rotation); a new beat is
//    popped from the queue only after the previous result is registered.
//  - Reset: length goes to 1, error sum to 0, queue and result register
//    empty. Stores and tables hold garbage until written.
//  - A stalled rsp holds its beat; the back end waits with the next result
//    until the output register is free.
module givens_qr_interval_update import gqiu_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  gqiu_in_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output gqiu_out_t rsp
);

    logic      cmd_valid;
    logic      cmd_pop;
    gqiu_cmd_t cmd;

    gqiu_front front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    gqiu_back back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // rejected beats never carry read data
    a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status) |->
        (rsp.read_u == '0 && rsp.read_a == '0 && rsp.read_b == '0))
        else $error("rejected beat carries read data");

    // interval length stays within the store
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(rsp.length) <= MAX_LEN))
        else $error("interval length beyond store size");

    // a full queue always presents a command to the back end
    a_queue_head: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> cmd_valid)
        else $error("queue full but no command offered");

    // a popped command is never lost: pop only with a valid head
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("back end popped an empty queue");

endmodule
